>>> rtl/core/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg
// Shared types, constants and helpers of the Givens rotation block.
// ----------------------------------------------------------------------------
package grs_pkg;

    localparam int MAX_DIM   = 64;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int SIZE_W    = 7;

    localparam logic [1:0] MODE_WRITE    = 2'd0;
    localparam logic [1:0] MODE_ROTATE   = 2'd1;
    localparam logic [1:0] MODE_READ     = 2'd2;
    localparam logic [1:0] MODE_IDENTITY = 2'd3;

    localparam logic signed [33:0] HALF_PI_Q29    = 34'sd843314857;
    localparam logic signed [33:0] QUARTER_PI_Q29 = 34'sd421657428;
    localparam logic [31:0]        ONE_Q30        = 32'h4000_0000;
    localparam logic [31:0]        ONE_Q27        = 32'h0800_0000;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
        logic [5:0]         col_p;
        logic [5:0]         col_q;
        logic signed [31:0] angle;
    } t_in;

    typedef struct packed {
        logic signed [31:0] element;
        logic               saturated;
    } t_out;

    // Request and answer between the sequencer and the trig unit.
    typedef struct packed {
        logic               start;
        logic signed [32:0] theta;
    } t_trig_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] c;
        logic signed [31:0] s;
    } t_trig_rsp;

    // Taylor divisors for step m, cosine and sine.
    function automatic logic [7:0] div_cos(input logic [2:0] m);
        logic [7:0] mm;
        mm = {5'd0, m};
        return 8'((2 * mm - 1) * (2 * mm));
    endfunction

    function automatic logic [7:0] div_sin(input logic [2:0] m);
        logic [7:0] mm;
        mm = {5'd0, m};
        return 8'((2 * mm) * (2 * mm + 1));
    endfunction

endpackage

>>> rtl/core/grs_if.sv
// ----------------------------------------------------------------------------
// grs_in_if / grs_out_if
// Valid-ready channels that carry commands into and results out of the block.
// ----------------------------------------------------------------------------
interface grs_in_if;
    logic           valid;
    logic           ready;
    grs_pkg::t_in   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface grs_out_if;
    logic           valid;
    logic           ready;
    grs_pkg::t_out  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/givens_rotation_sequence.sv
// ----------------------------------------------------------------------------
// givens_rotation_sequence
// Square Q5.27 matrix in one RAM, updated by Givens plane rotations.
// ----------------------------------------------------------------------------
// A write is taken every cycle while idle with no result waiting, and lands in
// the RAM at its accepting edge. A read result passes the RAM read register and
// then the output register; no new transaction is taken until it has been accepted.
// A rotation computes cosine and sine (seven series steps of two reciprocal
// divisions), then RQ, RP, MULY, WRY, WRX per row; identity sets all 4096 entries.
// Reset is synchronous: size 64, flag clear, RAM undefined until written.
module givens_rotation_sequence (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [6:0]       i_cfg_data,
    grs_in_if.sink           i_in,
    grs_out_if.source        o_out
);
    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_RD   = 10'b00_0000_0010,
        S_RDW  = 10'b00_0000_0100,
        S_TRIG = 10'b00_0000_1000,
        S_RQ   = 10'b00_0001_0000,
        S_RP   = 10'b00_0010_0000,
        S_MULY = 10'b00_0100_0000,
        S_WRY  = 10'b00_1000_0000,
        S_WRX  = 10'b01_0000_0000,
        S_CLR  = 10'b10_0000_0000
    } t_state;

    logic [31:0] r_mem [grs_pkg::DEPTH];
    logic [31:0] r_rdata;

    t_state                     r_state;
    logic [grs_pkg::SIZE_W-1:0] r_size;
    grs_pkg::t_in               r_cmd;
    logic                       r_sat;
    logic [grs_pkg::IDX_W:0]    r_row;
    logic [grs_pkg::ADDR_W-1:0] r_clr;
    logic signed [31:0]         r_x;
    logic signed [31:0]         r_y;
    logic                       r_ovalid;
    logic signed [31:0]         r_oelem;
    logic                       r_osat;
    logic                       r_rzero;
    grs_pkg::t_trig_req         r_treq;
    grs_pkg::t_trig_rsp         w_trsp;

    logic [grs_pkg::IDX_W:0]    w_n;
    logic                       w_we;
    logic [grs_pkg::ADDR_W-1:0] w_waddr;
    logic [31:0]                w_wdata;
    logic [grs_pkg::ADDR_W-1:0] w_raddr;
    logic                       w_load;
    logic                       w_neg;
    logic signed [31:0]         w_ma;
    logic signed [31:0]         w_mb;
    logic signed [31:0]         w_res;
    logic                       w_rsat;
    logic [grs_pkg::IDX_W-1:0]  w_ri;

    assign w_n  = (r_size == '0) ? 7'd1 :
                  (r_size > 7'(grs_pkg::MAX_DIM)) ? 7'(grs_pkg::MAX_DIM) : r_size;
    assign w_ri = r_row[grs_pkg::IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    grs_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_treq),
        .o_rsp   (w_trsp)
    );

    grs_rotor u_rotor (
        .i_clk  (i_clk),
        .i_load (w_load),
        .i_c    (w_trsp.c),
        .i_s    (w_trsp.s),
        .i_x    (w_ma),
        .i_y    (w_mb),
        .i_neg  (w_neg),
        .o_res  (w_res),
        .o_sat  (w_rsat)
    );

    // Multiplier operands: ny = c*y - s*x first, nx = c*x + s*y next.
    always_comb begin
        w_load = (r_state == S_MULY) || (r_state == S_WRY);
        w_neg  = (r_state == S_MULY);
        w_ma   = (r_state == S_MULY) ? $signed(r_rdata) : r_x;
        w_mb   = (r_state == S_MULY) ? r_x : r_y;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {w_ri, r_cmd.col_p};
        w_wdata = w_res;
        w_raddr = {w_ri, r_cmd.col_q};
        unique case (r_state)
            S_IDLE: begin
                w_raddr = {i_in.payload.row, i_in.payload.col};
                if (i_in.valid && i_in.ready && i_in.payload.mode == grs_pkg::MODE_WRITE
                    && {1'b0, i_in.payload.row} < w_n
                    && {1'b0, i_in.payload.col} < w_n) begin
                    w_we    = 1'b1;
                    w_waddr = {i_in.payload.row, i_in.payload.col};
                    w_wdata = i_in.payload.value;
                end
            end
            S_RP:  w_raddr = {w_ri, r_cmd.col_p};
            S_WRY: begin
                w_we = 1'b1;
            end
            S_WRX: begin
                w_we    = 1'b1;
                w_waddr = {w_ri, r_cmd.col_q};
            end
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = (r_clr[grs_pkg::ADDR_W-1:grs_pkg::IDX_W]
                           == r_clr[grs_pkg::IDX_W-1:0]
                           && {1'b0, r_clr[grs_pkg::ADDR_W-1:grs_pkg::IDX_W]} < w_n)
                          ? grs_pkg::ONE_Q27 : 32'd0;
            end
            default: ;
        endcase
    end

    assign i_in.ready      = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid     = r_ovalid;
    assign o_out.payload.element   = r_oelem;
    assign o_out.payload.saturated = r_osat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= 7'd64;
            r_sat    <= 1'b0;
            r_ovalid <= 1'b0;
            r_treq.start <= 1'b0;
        end else begin
            r_treq.start <= 1'b0;
            if (i_cfg_we) r_size <= i_cfg_data;
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_cmd <= i_in.payload;
                        r_row <= '0;
                        r_rzero <= !({1'b0, i_in.payload.row} < w_n
                                     && {1'b0, i_in.payload.col} < w_n);
                        case (i_in.payload.mode)
                            grs_pkg::MODE_READ: r_state <= S_RD;
                            grs_pkg::MODE_ROTATE: begin
                                if ({1'b0, i_in.payload.col_p} < w_n
                                    && {1'b0, i_in.payload.col_q} < w_n) begin
                                    r_treq.start <= 1'b1;
                                    r_treq.theta <= -33'(i_in.payload.angle);
                                    r_state <= S_TRIG;
                                end
                            end
                            grs_pkg::MODE_IDENTITY: begin
                                r_clr   <= '0;
                                r_sat   <= 1'b0;
                                r_state <= S_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    r_oelem  <= r_rzero ? 32'sd0 : $signed(r_rdata);
                    r_osat   <= r_sat;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_RDW: r_state <= S_IDLE;
                S_TRIG: if (w_trsp.done) r_state <= S_RQ;
                S_RQ:   r_state <= S_RP;
                S_RP: begin
                    r_x     <= r_rdata;
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_y     <= r_rdata;
                    r_state <= S_WRY;
                end
                S_WRY: begin
                    if (w_rsat) r_sat <= 1'b1;
                    r_state <= S_WRX;
                end
                S_WRX: begin
                    if (w_rsat) r_sat <= 1'b1;
                    r_row <= r_row + 7'd1;
                    r_state <= (r_row + 7'd1 >= w_n) ? S_IDLE : S_RQ;
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/grs_divider.sv
// ----------------------------------------------------------------------------
// grs_divider
// Floor division of a dividend by one of the series divisors, done by
// reciprocal multiplication and then one correction step.
// ----------------------------------------------------------------------------
module grs_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [7:0]  i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [31:0] r_num;
    logic [7:0]  r_den;
    logic [63:0] r_prod;
    logic        r_busy;
    logic        r_done;
    logic [31:0] r_q;
    logic [31:0] w_recip;
    logic [31:0] w_est;
    logic [39:0] w_back;
    logic [39:0] w_rem;

    // Reciprocal floor(2^32 / d) for every divisor that the series uses.
    always_comb begin
        unique case (i_den)
            8'd2:    w_recip = 32'd2147483648;
            8'd6:    w_recip = 32'd715827882;
            8'd12:   w_recip = 32'd357913941;
            8'd20:   w_recip = 32'd214748364;
            8'd30:   w_recip = 32'd143165576;
            8'd42:   w_recip = 32'd102261126;
            8'd56:   w_recip = 32'd76695844;
            8'd72:   w_recip = 32'd59652323;
            8'd90:   w_recip = 32'd47721858;
            8'd110:  w_recip = 32'd39045157;
            8'd132:  w_recip = 32'd32537631;
            8'd156:  w_recip = 32'd27531841;
            8'd182:  w_recip = 32'd23598721;
            8'd210:  w_recip = 32'd20452225;
            default: w_recip = 32'd0;
        endcase
    end

    // The estimate is the true quotient or one below it.
    assign w_est  = r_prod[63:32];
    assign w_back = {8'd0, w_est} * {32'd0, r_den};
    assign w_rem  = {8'd0, r_num} - w_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_prod <= {32'd0, i_num} * {32'd0, w_recip};
                r_num  <= i_num;
                r_den  <= i_den;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q    <= (w_rem >= {32'd0, r_den}) ? w_est + 32'd1 : w_est;
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

>>> rtl/core/grs_trig.sv
// ----------------------------------------------------------------------------
// grs_trig
// Cosine and sine in Q2.30 by range reduction and an eight-term Horner series.
// ----------------------------------------------------------------------------
module grs_trig (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  grs_pkg::t_trig_req  i_req,
    output grs_pkg::t_trig_rsp  o_rsp
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RED   = 8'b0000_0010,
        S_SQ    = 8'b0000_0100,
        S_MULC  = 8'b0000_1000,
        S_DIVC  = 8'b0001_0000,
        S_MULS  = 8'b0010_0000,
        S_DIVS  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state             r_state;
    logic signed [33:0] r_u;
    logic [3:0]         r_k;
    logic signed [33:0] r_r;
    logic [31:0]        r_a;
    logic [31:0]        r_x2;
    logic [31:0]        r_tc;
    logic [31:0]        r_ts;
    logic [2:0]         r_m;
    logic               r_ph;
    logic               r_dstart;
    logic [31:0]        r_dnum;
    logic [7:0]         r_dden;
    logic signed [31:0] r_c;
    logic signed [31:0] r_s;
    logic               r_done;
    logic               w_ddone;
    logic [31:0]        w_dq;
    logic [63:0]        w_prod;
    logic [31:0]        w_mul_b;
    logic [31:0]        w_mul_a;
    logic signed [31:0] w_cc;
    logic signed [31:0] w_ss;
    logic signed [33:0] w_absr;

    grs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_done  (w_ddone),
        .o_quot  (w_dq)
    );

    always_comb begin
        w_mul_a = r_x2;
        w_mul_b = r_tc;
        case (r_state)
            S_SQ:    begin w_mul_a = r_a; w_mul_b = r_a; end
            S_MULS:  begin w_mul_a = r_x2; w_mul_b = r_ts; end
            S_FIN:   begin w_mul_a = r_a; w_mul_b = r_ts; end
            default: begin w_mul_a = r_x2; w_mul_b = r_tc; end
        endcase
    end
    assign w_prod = {32'd0, w_mul_a} * {32'd0, w_mul_b};
    assign w_absr = r_r[33] ? -r_r : r_r;
    assign w_cc   = $signed(r_tc);
    assign w_ss   = r_r[33] ? -$signed(w_prod[61:30]) : $signed(w_prod[61:30]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dstart <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            r_done   <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_u   <= 34'(i_req.theta) + (grs_pkg::HALF_PI_Q29 <<< 2);
                        r_k   <= '0;
                        r_ph  <= 1'b0;
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    // Quotient by subtraction: k never exceeds seven.
                    if (!r_ph) begin
                        r_u  <= r_u + grs_pkg::QUARTER_PI_Q29;
                        r_ph <= 1'b1;
                    end else if (r_u >= grs_pkg::HALF_PI_Q29) begin
                        r_u <= r_u - grs_pkg::HALF_PI_Q29;
                        r_k <= r_k + 4'd1;
                    end else begin
                        r_r     <= r_u - grs_pkg::QUARTER_PI_Q29;
                        r_state <= S_SQ;
                        r_ph    <= 1'b0;
                    end
                end
                S_SQ: begin
                    if (!r_ph) begin
                        r_a  <= 32'(w_absr) << 1;
                        r_ph <= 1'b1;
                    end else begin
                        r_x2    <= w_prod[61:30];
                        r_tc    <= grs_pkg::ONE_Q30;
                        r_ts    <= grs_pkg::ONE_Q30;
                        r_m     <= 3'd7;
                        r_state <= S_MULC;
                    end
                end
                S_MULC: begin
                    r_dnum   <= w_prod[61:30];
                    r_dden   <= grs_pkg::div_cos(r_m);
                    r_dstart <= 1'b1;
                    r_state  <= S_DIVC;
                end
                S_DIVC: begin
                    if (w_ddone) begin
                        r_tc    <= grs_pkg::ONE_Q30 - w_dq;
                        r_state <= S_MULS;
                    end
                end
                S_MULS: begin
                    r_dnum   <= w_prod[61:30];
                    r_dden   <= grs_pkg::div_sin(r_m);
                    r_dstart <= 1'b1;
                    r_state  <= S_DIVS;
                end
                S_DIVS: begin
                    if (w_ddone) begin
                        r_ts <= grs_pkg::ONE_Q30 - w_dq;
                        r_m  <= r_m - 3'd1;
                        r_state <= (r_m == 3'd1) ? S_FIN : S_MULC;
                    end
                end
                S_FIN: begin
                    case (r_k[1:0])
                        2'd0:    begin r_c <= w_cc;  r_s <= w_ss;  end
                        2'd1:    begin r_c <= -w_ss; r_s <= w_cc;  end
                        2'd2:    begin r_c <= -w_cc; r_s <= -w_ss; end
                        default: begin r_c <= w_ss;  r_s <= -w_cc; end
                    endcase
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.c    = r_c;
    assign o_rsp.s    = r_s;
endmodule

>>> rtl/core/grs_rotor.sv
// ----------------------------------------------------------------------------
// grs_rotor
// Rotation datapath: two products per step, rounding and saturation to Q5.27.
// ----------------------------------------------------------------------------
module grs_rotor (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic signed [31:0] i_c,
    input  logic signed [31:0] i_s,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic               i_neg,
    output logic signed [31:0] o_res,
    output logic               o_sat
);
    // Result is c*x + s*y, or c*x - s*y when i_neg is set.
    logic signed [63:0] r_p0;
    logic signed [63:0] r_p1;
    logic               r_neg;
    logic signed [65:0] w_sum;
    logic signed [65:0] w_w;
    logic signed [35:0] w_q;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p0  <= i_c * i_x;
            r_p1  <= i_s * i_y;
            r_neg <= i_neg;
        end
    end

    assign w_sum = r_neg ? 66'(r_p0) - 66'(r_p1) : 66'(r_p0) + 66'(r_p1);
    assign w_w   = w_sum + 66'sd536870912;
    assign w_q   = 36'(w_w >>> 30);

    always_comb begin
        o_sat = 1'b0;
        o_res = w_q[31:0];
        if (w_q > 36'sd2147483647) begin
            o_sat = 1'b1;
            o_res = 32'sh7FFF_FFFF;
        end else if (w_q < -36'sd2147483648) begin
            o_sat = 1'b1;
            o_res = 32'sh8000_0000;
        end
    end
endmodule
